// ----- rtl/core/qpht_pkg.sv -----
// Shared constants, codes and entry format for the quadratic probe hash table.
package qpht_pkg;

    localparam int KEY_W    = 31;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int TAG_W    = 2;
    localparam int ENTRY_W  = TAG_W + KEY_W;
    localparam int S_TDATA_W = ((MODE_W + KEY_W + 7) / 8) * 8;

    localparam int INITIAL_SLOTS_DEF = 5;
    localparam int MAX_SLOTS_DEF     = 1597;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd5;

    // slot tags, stored above the key
    localparam logic [TAG_W-1:0] TAG_EMPTY   = 2'd0;
    localparam logic [TAG_W-1:0] TAG_DELETED = 2'd1;
    localparam logic [TAG_W-1:0] TAG_LIVE    = 2'd2;

endpackage

// ----- rtl/core/qpht_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/qpht_div.sv -----
// Restoring remainder unit: one dividend bit per cycle.
module qpht_div #(
    parameter int DIV_W = 12
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [qpht_pkg::KEY_W-1:0] dividend,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     done,
    output logic [DIV_W-1:0]         rem
);

    localparam int KW    = qpht_pkg::KEY_W;
    localparam int CNT_W = $clog2(KW + 1);

    logic [KW-1:0]    a_reg;
    logic [DIV_W-1:0] b_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] trial_sub;
    logic [DIV_W-1:0] rem_next;

    always_comb begin
        trial     = {rem_reg, a_reg[KW-1]};
        trial_sub = trial - {1'b0, b_reg};
        rem_next  = (trial >= {1'b0, b_reg}) ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= dividend;
                b_reg    <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(KW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                a_reg   <= {a_reg[KW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/core/quadratic_probe_hash_table_unit.sv -----
// Top level: open-addressing hash table with quadratic probing and growth.
// An operation runs a home-slot remainder, then a probe loop (address, compare), then the output
// register; unused modes answer directly. Throughput: one word at a time, ready only idle.
// Growth adds a prime search by trial division, a clear of the new bank, and a pass over
// the old slots that reinserts each live key by remainder and probing.
// Reset (synchronous, active low) runs the initial prime search and a clearing pass over
// the table-size slots of the first bank; no word is accepted until that finishes.
module quadratic_probe_hash_table_unit #(
    parameter int INITIAL_SLOTS = qpht_pkg::INITIAL_SLOTS_DEF,
    parameter int MAX_SLOTS     = qpht_pkg::MAX_SLOTS_DEF,
    localparam int SLOT_W       = $clog2(MAX_SLOTS),
    localparam int M_TDATA_W    = ((qpht_pkg::STATUS_W + SLOT_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: mode [1:0], key [32:2]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [qpht_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: status [2:0], slot_index [SLOT_W+2:3]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_TDATA_W-1:0]           m_tdata
);

    localparam int KW      = qpht_pkg::KEY_W;
    localparam int EW      = qpht_pkg::ENTRY_W;
    localparam int SW      = qpht_pkg::STATUS_W;
    localparam int SIZE_W  = $clog2(MAX_SLOTS + 1);
    localparam int CW      = SIZE_W + 1;   // prime candidate, up to twice a size
    localparam int GW      = SIZE_W + 3;   // load check products
    localparam int INIT_C0 = (INITIAL_SLOTS < 2) ? 2 : INITIAL_SLOTS;
    localparam int INIT_C  = (INIT_C0 > MAX_SLOTS) ? MAX_SLOTS : INIT_C0;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SLOTS);

    // sequencer states
    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_PR_CHK   = 10'b00_0000_0010,  // prime search: bound tests
        ST_PR_DIV   = 10'b00_0000_0100,  // prime search: trial division
        ST_CLR      = 10'b00_0000_1000,  // clear target bank
        ST_RH_RD    = 10'b00_0001_0000,  // rehash: read old slot
        ST_RH_CHK   = 10'b00_0010_0000,
        ST_HOME_DIV = 10'b00_0100_0000,  // key mod size
        ST_PB_RD    = 10'b00_1000_0000,  // probe: address
        ST_PB_CHK   = 10'b01_0000_0000,  // probe: compare
        ST_DONE     = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic                bank_reg, bank_next;      // bank holding the live table
    logic [SIZE_W-1:0]   ts_reg, ts_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]       ns_reg, ns_next;          // prime candidate, then new size
    logic [CW-1:0]       dv_reg, dv_next;          // trial divisor
    logic [CW:0]         sq_reg, sq_next;          // dv squared
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]   p_reg, p_next;            // probe slot
    logic [SLOT_W-1:0]   pd_reg, pd_next;          // (2j+1) mod size
    logic [SIZE_W-1:0]   j_reg, j_next;
    logic [qpht_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [KW-1:0]       rkey_reg, rkey_next;      // key being rehashed
    logic                rh_reg, rh_next;          // probing the new bank
    logic                init_reg, init_next;      // prime search after reset
    logic [SW-1:0]       res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                m_valid_reg, m_valid_next;
    logic [SW-1:0]       out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    // memory ports
    logic                we, wsel;
    logic [SLOT_W-1:0]   waddr, raddr;
    logic [EW-1:0]       wdata, rdata0, rdata1, cur_rdata, oth_rdata;

    // shared remainder unit
    logic                div_start, div_done;
    logic [KW-1:0]       div_a;
    logic [CW-1:0]       div_b, div_rem;

    logic [qpht_pkg::MODE_W-1:0] s_mode;
    logic [KW-1:0]       s_key;
    logic                grow_cond;
    logic [CW-1:0]       found;
    logic [SIZE_W-1:0]   sz, idx_p1, clr_lim;
    logic [SLOT_W:0]     szx, p_sum, pd_sum;
    logic [SLOT_W-1:0]   p_step, pd_step;
    logic                rh_adv;
    logic [qpht_pkg::TAG_W-1:0] pb_tag;
    logic [KW-1:0]       pb_key;

    assign s_mode = s_tdata[qpht_pkg::MODE_W-1:0];
    assign s_key  = s_tdata[qpht_pkg::MODE_W +: KW];

    // grow when load reaches 0.8: 5*count >= 4*size
    assign grow_cond = ((GW'(cnt_reg) << 2) + GW'(cnt_reg)) >= (GW'(ts_reg) << 2);

    assign found  = (ns_reg >= MAX_C) ? MAX_C : ns_reg;
    assign sz     = rh_reg ? ns_reg[SIZE_W-1:0] : ts_reg;
    assign idx_p1 = SIZE_W'(idx_reg) + SIZE_W'(1);
    assign clr_lim = init_reg ? ts_reg : ns_reg[SIZE_W-1:0];

    // next probe: p += (2j+1), step += 2, both mod size
    assign szx     = (SLOT_W + 1)'(sz);
    assign p_sum   = {1'b0, p_reg} + {1'b0, pd_reg};
    assign pd_sum  = {1'b0, pd_reg} + (SLOT_W + 1)'(2);
    assign p_step  = (p_sum >= szx) ? SLOT_W'(p_sum - szx) : SLOT_W'(p_sum);
    assign pd_step = (pd_sum >= szx) ? SLOT_W'(pd_sum - szx) : SLOT_W'(pd_sum);

    assign cur_rdata = bank_reg ? rdata1 : rdata0;
    assign oth_rdata = bank_reg ? rdata0 : rdata1;
    assign pb_tag    = rh_reg ? oth_rdata[EW-1:KW] : cur_rdata[EW-1:KW];
    assign pb_key    = cur_rdata[KW-1:0];

    always_comb begin
        state_next      = state_reg;
        bank_next       = bank_reg;
        ts_next         = ts_reg;
        cnt_next        = cnt_reg;
        ns_next         = ns_reg;
        dv_next         = dv_reg;
        sq_next         = sq_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        pd_next         = pd_reg;
        j_next          = j_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        rkey_next       = rkey_reg;
        rh_next         = rh_reg;
        init_next       = init_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        we        = 1'b0;
        wsel      = bank_reg;
        waddr     = p_reg;
        wdata     = '0;
        raddr     = p_reg;
        div_start = 1'b0;
        div_a     = key_reg;
        div_b     = CW'(ts_reg);
        rh_adv    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next = s_mode;
                    key_next  = s_key;
                    rh_next   = 1'b0;
                    div_a     = s_key;
                    case (s_mode)
                        qpht_pkg::MODE_INSERT: begin
                            if (grow_cond) begin
                                init_next  = 1'b0;
                                ns_next    = {ts_reg, 1'b0};
                                dv_next    = CW'(2);
                                sq_next    = (CW + 1)'(4);
                                state_next = ST_PR_CHK;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_HOME_DIV;
                            end
                        end
                        qpht_pkg::MODE_REMOVE, qpht_pkg::MODE_SEARCH: begin
                            div_start  = 1'b1;
                            state_next = ST_HOME_DIV;
                        end
                        default: begin
                            res_status_next = qpht_pkg::STATUS_NOT_FOUND;
                            res_slot_next   = '0;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PR_CHK: begin
                if (ns_reg >= MAX_C || sq_reg > {1'b0, ns_reg}) begin
                    ns_next  = found;
                    idx_next = '0;
                    if (init_reg) begin
                        ts_next    = found[SIZE_W-1:0];
                        state_next = ST_CLR;
                    end else if (found > CW'(ts_reg)) begin
                        state_next = ST_CLR;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_HOME_DIV;
                    end
                end else begin
                    div_start  = 1'b1;
                    div_a      = KW'(ns_reg);
                    div_b      = dv_reg;
                    state_next = ST_PR_DIV;
                end
            end
            ST_PR_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        ns_next = ns_reg + CW'(1);
                        dv_next = CW'(2);
                        sq_next = (CW + 1)'(4);
                    end else begin
                        sq_next = sq_reg + {dv_reg, 1'b0} + (CW + 1)'(1);
                        dv_next = dv_reg + CW'(1);
                    end
                    state_next = ST_PR_CHK;
                end
            end
            ST_CLR: begin
                we    = 1'b1;
                wsel  = init_reg ? bank_reg : ~bank_reg;
                waddr = idx_reg;
                wdata = '0;
                if (idx_p1 == clr_lim) begin
                    idx_next   = '0;
                    state_next = init_reg ? ST_IDLE : ST_RH_RD;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_RH_RD: begin
                raddr      = idx_reg;
                state_next = ST_RH_CHK;
            end
            ST_RH_CHK: begin
                if (cur_rdata[EW-1:KW] == qpht_pkg::TAG_LIVE) begin
                    rkey_next  = pb_key;
                    div_start  = 1'b1;
                    div_a      = pb_key;
                    div_b      = ns_reg;
                    rh_next    = 1'b1;
                    state_next = ST_HOME_DIV;
                end else begin
                    rh_adv = 1'b1;
                end
            end
            ST_HOME_DIV: begin
                if (div_done) begin
                    p_next     = div_rem[SLOT_W-1:0];
                    pd_next    = SLOT_W'(1);
                    j_next     = '0;
                    state_next = ST_PB_RD;
                end
            end
            ST_PB_RD: begin
                if (j_reg == sz) begin
                    if (rh_reg) begin
                        // key found no place in the new bank: dropped
                        if (cnt_reg != '0) begin
                            cnt_next = cnt_reg - SIZE_W'(1);
                        end
                        rh_adv = 1'b1;
                    end else begin
                        res_status_next = (mode_reg == qpht_pkg::MODE_INSERT) ?
                                          qpht_pkg::STATUS_FULL : qpht_pkg::STATUS_NOT_FOUND;
                        res_slot_next   = '0;
                        state_next      = ST_DONE;
                    end
                end else begin
                    state_next = ST_PB_CHK;
                end
            end
            ST_PB_CHK: begin
                p_next     = p_step;
                pd_next    = pd_step;
                j_next     = j_reg + SIZE_W'(1);
                state_next = ST_PB_RD;
                if (rh_reg) begin
                    if (pb_tag == qpht_pkg::TAG_EMPTY) begin
                        we     = 1'b1;
                        wsel   = ~bank_reg;
                        wdata  = {qpht_pkg::TAG_LIVE, rkey_reg};
                        rh_adv = 1'b1;
                    end
                end else if (pb_tag == qpht_pkg::TAG_LIVE && pb_key == key_reg) begin
                    res_slot_next = p_reg;
                    state_next    = ST_DONE;
                    if (mode_reg == qpht_pkg::MODE_INSERT) begin
                        res_status_next = qpht_pkg::STATUS_DUPLICATE;
                    end else if (mode_reg == qpht_pkg::MODE_REMOVE) begin
                        we    = 1'b1;
                        wdata = {qpht_pkg::TAG_DELETED, KW'(0)};
                        if (cnt_reg != '0) begin
                            cnt_next = cnt_reg - SIZE_W'(1);
                        end
                        res_status_next = qpht_pkg::STATUS_REMOVED;
                    end else begin
                        res_status_next = qpht_pkg::STATUS_FOUND;
                    end
                end else if (mode_reg == qpht_pkg::MODE_INSERT) begin
                    if (pb_tag == qpht_pkg::TAG_EMPTY || pb_tag == qpht_pkg::TAG_DELETED) begin
                        we              = 1'b1;
                        wdata           = {qpht_pkg::TAG_LIVE, key_reg};
                        cnt_next        = cnt_reg + SIZE_W'(1);
                        res_status_next = qpht_pkg::STATUS_INSERTED;
                        res_slot_next   = p_reg;
                        state_next      = ST_DONE;
                    end
                end else if (pb_tag == qpht_pkg::TAG_EMPTY) begin
                    res_status_next = qpht_pkg::STATUS_NOT_FOUND;
                    res_slot_next   = '0;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // move on to the next old slot, or swap banks once all are rehashed
        if (rh_adv) begin
            if (idx_p1 == ts_reg) begin
                bank_next  = ~bank_reg;
                ts_next    = ns_reg[SIZE_W-1:0];
                rh_next    = 1'b0;
                div_start  = 1'b1;
                div_a      = key_reg;
                div_b      = ns_reg;
                state_next = ST_HOME_DIV;
            end else begin
                idx_next   = idx_reg + SLOT_W'(1);
                rh_next    = 1'b0;
                state_next = ST_RH_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_PR_CHK;
            init_reg    <= 1'b1;
            ns_reg      <= CW'(INIT_C);
            dv_reg      <= CW'(2);
            sq_reg      <= (CW + 1)'(4);
            bank_reg    <= 1'b0;
            ts_reg      <= '0;
            cnt_reg     <= '0;
            rh_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            ns_reg      <= ns_next;
            dv_reg      <= dv_next;
            sq_reg      <= sq_next;
            bank_reg    <= bank_next;
            ts_reg      <= ts_next;
            cnt_reg     <= cnt_next;
            rh_reg      <= rh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        p_reg          <= p_next;
        pd_reg         <= pd_next;
        j_reg          <= j_next;
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        rkey_reg       <= rkey_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    qpht_div #(
        .DIV_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .rem      (div_rem)
    );

    qpht_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_bank0 (
        .aclk  (aclk),
        .we    (we && !wsel),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    qpht_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_bank1 (
        .aclk  (aclk),
        .we    (we && wsel),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_slot_reg, out_status_reg});

endmodule

// ----- rtl/core/qpht_checker.sv -----
// Port-level assertions for the hash table unit, bound to the top level.
module qpht_checker #(
    parameter int MAX_SLOTS = qpht_pkg::MAX_SLOTS_DEF,
    localparam int SLOT_W    = $clog2(MAX_SLOTS),
    localparam int M_TDATA_W = ((qpht_pkg::STATUS_W + SLOT_W + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [qpht_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [M_TDATA_W-1:0]           m_tdata
);

    logic [qpht_pkg::STATUS_W-1:0] st;
    logic [SLOT_W-1:0]             slot;

    assign st   = m_tdata[qpht_pkg::STATUS_W-1:0];
    assign slot = m_tdata[qpht_pkg::STATUS_W +: SLOT_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st <= qpht_pkg::STATUS_FOUND)
        else $error("status code out of range");

    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == qpht_pkg::STATUS_FULL || st == qpht_pkg::STATUS_NOT_FOUND)
        |-> slot == '0)
        else $error("slot not zero on a miss");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind quadratic_probe_hash_table_unit qpht_checker #(
    .MAX_SLOTS (MAX_SLOTS)
) u_qpht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
